// File: sv/integer_to_ascii_formatter_defines.svh
// Assertion helpers shared by the checker.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2A_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/i2a_pkg.sv
package i2a_pkg;

    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int WIDTH_W = 8;
    localparam int CHAR_W  = 8;

    localparam logic [KIND_W-1:0] KIND_CHAR = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SDEC = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UDEC = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEX  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PCT  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;

    // Fixed text goes out lowest byte first, so "ERROR" is stored reversed.
    localparam int TXT_LEN = 5;
    localparam int TXT_W   = TXT_LEN * CHAR_W;
    localparam int TXT_CW  = 3;
    localparam logic [TXT_W-1:0]  ERR_TEXT = "RORRE";
    localparam logic [TXT_CW-1:0] ERR_LEN  = 3'd5;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] dig);
        return DIGIT_CHARS[dig];
    endfunction

endpackage

// File: sv/integer_to_ascii_formatter.sv
// Character, percent and ERROR words are accepted into S_TEXT and load into the output
// register from there. Decimal shifts one value bit per cycle in S_CONV, then drops leading
// zero digits in S_SKIP to find the top digit, sizes the fill in S_PREP, then sends one
// word per cycle while out_ready does not stall the output. Hex skips the bit shifting.
// One conversion at a time: the next is accepted the cycle after the last word loads.
// Reset (rst_n low, asynchronous) returns to idle and drops out_valid.
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = 32,
    parameter int PAD_LIMIT  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [i2a_pkg::KIND_W-1:0]    kind,
    input  logic [i2a_pkg::VALUE_W-1:0]   value,
    input  logic [i2a_pkg::WIDTH_W-1:0]   width,
    input  logic                          zero_fill,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [i2a_pkg::CHAR_W-1:0]    out_char,
    output logic                          last
);
    import i2a_pkg::*;

    // Decimal digits needed for VALUE_BITS (log10(2) ~ 0.30103), and hex digits.
    localparam int ND     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NHEX   = (VALUE_BITS + 3) / 4;
    localparam int DW     = ND * 4;
    localparam int DCW    = $clog2(ND + 1);
    localparam int BCW    = $clog2(VALUE_BITS + 1);
    localparam int FILL_W = $clog2(PAD_LIMIT);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CONV = 9'b000000010,
        S_SKIP = 9'b000000100,
        S_PREP = 9'b000001000,
        S_LEAD = 9'b000010000,
        S_FILL = 9'b000100000,
        S_SIGN = 9'b001000000,
        S_DIGS = 9'b010000000,
        S_TEXT = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  bin_reg, bin_next;
    logic [DW-1:0]          dig_reg, dig_next;
    logic [DCW-1:0]         dcnt_reg, dcnt_next;
    logic [BCW-1:0]         bcnt_reg, bcnt_next;
    logic                   neg_reg, neg_next;
    logic                   zf_reg, zf_next;
    logic [WIDTH_W-1:0]     width_reg, width_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [TXT_W-1:0]       txt_reg, txt_next;
    logic [TXT_CW-1:0]      tcnt_reg, tcnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                   last_reg, last_next;

    logic [VALUE_BITS-1:0]  v_ext;
    logic [NHEX*4-1:0]      hex_pad;
    logic [DW-1:0]          adj;
    logic [9:0]             r_cnt;
    logic                   fill_on;
    logic                   emit_go;
    logic [3:0]             top_dig;

    assign v_ext   = VALUE_BITS'(value);
    assign hex_pad = (NHEX * 4)'(v_ext);
    assign top_dig = dig_reg[DW-1 -: 4];
    assign emit_go = !out_valid_reg || out_ready;

    // r = width - (d - 1) - sign, kept modulo 1024; bit 9 marks a negative count.
    assign r_cnt   = 10'(width_reg) - 10'(dcnt_reg) + 10'd1 - 10'(neg_reg);
    assign fill_on = !r_cnt[9] && (r_cnt[8:0] >= 9'd2) && (r_cnt[8:0] <= 9'(PAD_LIMIT - 1));

    // Add-3 correction on every BCD digit before the shift.
    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            adj[i*4 +: 4] = (dig_reg[i*4 +: 4] >= 4'd5) ? dig_reg[i*4 +: 4] + 4'd3
                                                          : dig_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        dig_next       = dig_reg;
        dcnt_next      = dcnt_reg;
        bcnt_next      = bcnt_reg;
        neg_next       = neg_reg;
        zf_next        = zf_reg;
        width_next     = width_reg;
        fill_next      = fill_reg;
        txt_next       = txt_reg;
        tcnt_next      = tcnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    width_next = width;
                    zf_next    = zero_fill;
                    neg_next   = 1'b0;
                    case (kind)
                        KIND_CHAR:
                        begin
                            txt_next   = TXT_W'(value[CHAR_W-1:0]);
                            tcnt_next  = TXT_CW'(1);
                            state_next = S_TEXT;
                        end
                        KIND_PCT:
                        begin
                            txt_next   = TXT_W'(CH_PCT);
                            tcnt_next  = TXT_CW'(1);
                            state_next = S_TEXT;
                        end
                        KIND_SDEC, KIND_UDEC:
                        begin
                            neg_next   = (kind == KIND_SDEC) && v_ext[VALUE_BITS-1];
                            bin_next   = ((kind == KIND_SDEC) && v_ext[VALUE_BITS-1])
                                         ? (~v_ext + VALUE_BITS'(1)) : v_ext;
                            dig_next   = '0;
                            bcnt_next  = BCW'(VALUE_BITS);
                            state_next = S_CONV;
                        end
                        KIND_HEX:
                        begin
                            dig_next   = DW'(hex_pad) << ((ND - NHEX) * 4);
                            dcnt_next  = DCW'(NHEX);
                            state_next = S_SKIP;
                        end
                        default:
                        begin
                            txt_next   = ERR_TEXT;
                            tcnt_next  = ERR_LEN;
                            state_next = S_TEXT;
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                dig_next  = {adj[DW-2:0], bin_reg[VALUE_BITS-1]};
                bin_next  = bin_reg << 1;
                bcnt_next = bcnt_reg - BCW'(1);
                if (bcnt_reg == BCW'(1))
                begin
                    dcnt_next  = DCW'(ND);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Drop leading zero digits, keeping at least one.
                if (top_dig == 4'd0 && dcnt_reg != DCW'(1))
                begin
                    dig_next  = dig_reg << 4;
                    dcnt_next = dcnt_reg - DCW'(1);
                end
                else
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                fill_next = fill_on ? FILL_W'(r_cnt[8:0] - 9'd1) : '0;
                if (neg_reg && zf_reg)
                begin
                    state_next = S_LEAD;
                end
                else if (fill_on)
                begin
                    state_next = S_FILL;
                end
                else if (neg_reg)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_DIGS;
                end
            end
            S_LEAD:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_MINUS;
                    last_next      = 1'b0;
                    state_next     = (fill_reg != '0) ? S_FILL : S_DIGS;
                end
            end
            S_FILL:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = zf_reg ? CH_ZERO : CH_SPACE;
                    last_next      = 1'b0;
                    fill_next      = fill_reg - FILL_W'(1);
                    if (fill_reg == FILL_W'(1))
                    begin
                        state_next = (neg_reg && !zf_reg) ? S_SIGN : S_DIGS;
                    end
                end
            end
            S_SIGN:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_MINUS;
                    last_next      = 1'b0;
                    state_next     = S_DIGS;
                end
            end
            S_DIGS:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(top_dig);
                    last_next      = (dcnt_reg == DCW'(1));
                    dig_next       = dig_reg << 4;
                    dcnt_next      = dcnt_reg - DCW'(1);
                    if (dcnt_reg == DCW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_TEXT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = txt_reg[CHAR_W-1:0];
                    last_next      = (tcnt_reg == TXT_CW'(1));
                    txt_next       = txt_reg >> CHAR_W;
                    tcnt_next      = tcnt_reg - TXT_CW'(1);
                    if (tcnt_reg == TXT_CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        dig_reg      <= dig_next;
        dcnt_reg     <= dcnt_next;
        bcnt_reg     <= bcnt_next;
        neg_reg      <= neg_next;
        zf_reg       <= zf_next;
        width_reg    <= width_next;
        fill_reg     <= fill_next;
        txt_reg      <= txt_next;
        tcnt_reg     <= tcnt_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

// File: sv/i2a_checker.sv
`include "integer_to_ascii_formatter_defines.svh"

module i2a_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [i2a_pkg::CHAR_W-1:0]    out_char,
    input logic                          last
);

    // A stalled word keeps its character and end mark.
    `I2A_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_char) && $stable(last), "output word changed while stalled")

    // Taking a conversion makes the block busy in the next cycle.
    `I2A_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "input still ready right after a conversion was taken")

    // While ready for a new conversion, only the final word of the previous one may wait.
    `I2A_ASSERT_NOW(a_idle_only_last, in_ready && out_valid, last,
        "ready for input while a non-final word is pending")

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (.*);

// File: verif/tb.sv
module tb;
    import i2a_pkg::*;

    // Kinds with no name in the package all format as the error text.
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    localparam int TEXT_BYTES = 16;
    localparam logic [TEXT_BYTES*8-1:0] PREDICTED = '0;
    localparam int ROWS = 24;
    localparam int RANDOM_PER_PHASE = 135;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [VALUE_W-1:0]        value;
        logic [WIDTH_W-1:0]        width;
        logic                      zero_fill;
        logic [TEXT_BYTES*8-1:0]   text;
    } conv_row_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [KIND_W-1:0]    kind;
    logic [VALUE_W-1:0]   value;
    logic [WIDTH_W-1:0]   width;
    logic                 zero_fill;
    logic                 out_valid;
    logic                 out_ready;
    logic [CHAR_W-1:0]    out_char;
    logic                 last;

    char_word_t expected_chars[$];
    int send_idle_pct = 15;
    int recv_idle_pct = 46;
    int error_count = 0;
    int conversions_sent = 0;
    int chars_checked = 0;
    int cycle_count = 0;

    // Expectations are typed in where a glance suffices; other rows use the predictor.
    conv_row_t directed_rows [ROWS] = '{
        '{KIND_CHAR,    32'h0000_0041, 8'd0,   1'b0, "A"},
        '{KIND_CHAR,    32'hFFFF_FF7E, 8'd255, 1'b1, "~"},
        '{KIND_CHAR,    32'h0000_0100, 8'd0,   1'b0, PREDICTED},
        '{KIND_PCT,     32'hFFFF_FFFF, 8'd255, 1'b1, "%"},
        '{KIND_UNKNOWN, 32'h0000_0000, 8'd0,   1'b0, "ERROR"},
        '{KIND_SPARE_A, 32'h1234_5678, 8'd9,   1'b0, "ERROR"},
        '{KIND_SPARE_B, 32'hFFFF_FFFF, 8'd255, 1'b1, "ERROR"},
        '{KIND_UDEC,    32'h0000_0000, 8'd0,   1'b0, "0"},
        '{KIND_UDEC,    32'hFFFF_FFFF, 8'd0,   1'b0, "4294967295"},
        '{KIND_SDEC,    32'h8000_0000, 8'd0,   1'b0, "-2147483648"},
        '{KIND_SDEC,    32'h8000_0000, 8'd25,  1'b1, PREDICTED},
        '{KIND_SDEC,    32'hFFFF_FFFF, 8'd0,   1'b0, "-1"},
        '{KIND_SDEC,    32'h7FFF_FFFF, 8'd0,   1'b0, "2147483647"},
        '{KIND_SDEC,    32'h0000_0000, 8'd0,   1'b1, "0"},
        '{KIND_HEX,     32'hFFFF_FFFF, 8'd0,   1'b0, "ffffffff"},
        '{KIND_HEX,     32'hDEAD_BEEF, 8'd12,  1'b1, "0000deadbeef"},
        '{KIND_SDEC,    32'hFFFF_FFFB, 8'd6,   1'b1, "-00005"},
        '{KIND_SDEC,    32'hFFFF_FFFB, 8'd6,   1'b0, "    -5"},
        '{KIND_UDEC,    32'h0000_0007, 8'd15,  1'b0, PREDICTED},
        '{KIND_UDEC,    32'h0000_0007, 8'd16,  1'b1, "7"},
        '{KIND_UDEC,    32'h0000_002A, 8'd2,   1'b1, "42"},
        '{KIND_UDEC,    32'h0000_002A, 8'd3,   1'b1, "042"},
        '{KIND_SDEC,    32'hFFFF_FFFF, 8'd255, 1'b1, "-1"},
        '{KIND_HEX,     32'h0000_0000, 8'd8,   1'b0, PREDICTED}
    };

    integer_to_ascii_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .width     (width),
        .zero_fill (zero_fill),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void push_line(input logic [CHAR_W-1:0] line[$]);
        char_word_t w;
        for (int i = 0; i < line.size(); i++)
        begin
            w.ch = line[i];
            w.last = (i == line.size() - 1);
            expected_chars.push_back(w);
        end
    endfunction

    // Works out the characters of one conversion.
    function automatic void format_conversion(input conv_row_t row);
        logic [CHAR_W-1:0] line[$];
        logic [CHAR_W-1:0] digits[$];
        logic [VALUE_W-1:0] mag;
        logic [TXT_W-1:0] err_word;
        logic [3:0] dv;
        int base;
        int d;
        int r;
        bit neg;
        err_word = "ERROR";
        case (row.kind)
            KIND_CHAR: line.push_back(row.value[7:0]);
            KIND_PCT: line.push_back(CH_PCT);
            KIND_SDEC, KIND_UDEC, KIND_HEX:
            begin
                base = (row.kind == KIND_HEX) ? 16 : 10;
                neg = (row.kind == KIND_SDEC) && row.value[VALUE_W-1];
                mag = neg ? (~row.value + 1'b1) : row.value;
                do
                begin
                    dv = 4'(mag % base);
                    digits.push_front(digit_char(dv));
                    mag = mag / base;
                end while (mag != 0);
                d = digits.size();
                r = int'(row.width) - (d - 1) - (neg ? 1 : 0);
                if (neg && row.zero_fill)
                    line.push_back(CH_MINUS);
                if (r >= 2 && r <= 15)
                    for (int i = 0; i < r - 1; i++)
                        line.push_back(row.zero_fill ? CH_ZERO : CH_SPACE);
                if (neg && !row.zero_fill)
                    line.push_back(CH_MINUS);
                for (int i = 0; i < d; i++)
                    line.push_back(digits[i]);
            end
            default:
                for (int i = TXT_LEN - 1; i >= 0; i--)
                    line.push_back(err_word[i*8 +: 8]);
        endcase
        push_line(line);
    endfunction

    // A typed expectation is right-justified in the text field, zero bytes ahead of it.
    function automatic void queue_text(input logic [TEXT_BYTES*8-1:0] text);
        logic [CHAR_W-1:0] line[$];
        int top;
        top = TEXT_BYTES - 1;
        while (top > 0 && text[top*8 +: 8] == 8'h00)
            top--;
        for (int i = top; i >= 0; i--)
            line.push_back(text[i*8 +: 8]);
        push_line(line);
    endfunction

    function automatic conv_row_t random_row();
        conv_row_t row;
        int pick;
        pick = $urandom_range(0, 99);
        row.text = PREDICTED;
        row.zero_fill = 1'($urandom_range(0, 1));
        if (pick < 8)
            row.kind = KIND_CHAR;
        else if (pick < 12)
            row.kind = KIND_PCT;
        else if (pick < 18)
            row.kind = 3'($urandom_range(5, 7));
        else
            row.kind = 3'($urandom_range(1, 3));
        case ($urandom_range(0, 4))
            0: row.value = $urandom;
            1: row.value = $urandom_range(0, 999);
            2: row.value = -$urandom_range(1, 999);
            3: row.value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            default: row.value = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 9) < 7)
            row.width = 8'($urandom_range(0, 26));
        else
            row.width = 8'($urandom_range(0, 255));
        return row;
    endfunction

    // Offers one word and returns at the rising edge that takes it.
    task automatic send_row(input conv_row_t row);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        kind <= row.kind;
        value <= row.value;
        width <= row.width;
        zero_fill <= row.zero_fill;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (row.text == PREDICTED)
            format_conversion(row);
        else
            queue_text(row.text);
        conversions_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase(input int sender_idle, input int receiver_idle);
        wait_for_drain();
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_row(random_row());
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_output
        char_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected word, actual char 0x%02h last %0b",
                         $time, out_char, last);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (out_char !== want.ch)
                begin
                    $display("%0t: out_char mismatch, expected 0x%02h actual 0x%02h",
                             $time, want.ch, out_char);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, want.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d words outstanding", $time,
                     expected_chars.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = '0;
        value = '0;
        width = '0;
        zero_fill = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < ROWS; i++)
            send_row(directed_rows[i]);

        // Each phase first holds the sender off until every pending word is out.
        run_random_phase(15, 46);
        run_random_phase(46, 15);
        run_random_phase(0, 0);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_chars.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, expected_chars.size());
            error_count++;
        end
        $display("Sent %0d conversions (directed corners, then random under three idle mixes)",
                 conversions_sent);
        $display("and checked %0d output words, %0d errors.", chars_checked, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: integer_to_ascii_formatter.f
+incdir+sv
sv/i2a_pkg.sv
sv/integer_to_ascii_formatter.sv
sv/i2a_checker.sv
verif/tb.sv
